// ===== rtl/deq_eng_pkg.sv =====
// Shared types and constants for the double-ended queue engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package deq_eng_pkg;

   // default ring store depth
   localparam int DEPTH_DEFAULT = 64;

   // key width, fixed by the item format
   localparam int KEY_W = 32;

   // request opcodes
   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_BACK  = 2'd1,
      OP_DUMP_FWD   = 2'd2,
      OP_DUMP_REV   = 2'd3
   } op_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_ACCEPT = 2'd0,
      ST_FULL   = 2'd1,
      ST_ELEM   = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   // controller -> datapath commands
   typedef struct packed {
      logic do_push;     // store key, bump count
      logic at_front;    // push goes to the front
      logic do_full;     // answer push rejected
      logic do_empty;    // answer empty dump
      logic dump_start;  // first element read of a dump
      logic reverse;     // dump back to front
      logic dump_step;   // next element read of a running dump
   } deq_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic full;        // count at depth
      logic empty;       // count zero
      logic single;      // exactly one key held
      logic final_elem;  // next dump read is the last one
      logic rsp_free;    // output register can take a new result
   } deq_stat_type;

endpackage

`default_nettype wire

// ===== rtl/deq_eng_dp.sv =====
// Datapath: ring store, front index, count, dump cursor and output register.
// Depends on deq_eng_pkg; driven by deq_eng_ctrl commands.
`default_nettype none

module deq_eng_dp import deq_eng_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire deq_cmd_type             cmd,
   input  wire logic signed [KEY_W-1:0] key_in,
   input  wire logic                    rsp_ready,
   output deq_stat_type                 stat,
   output logic                         rsp_valid,
   output logic signed [KEY_W-1:0]      rsp_key_out,
   output logic [1:0]                   rsp_status,
   output logic                         rsp_last
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   // slot of (base + ofs) mod DEPTH; both operands stay below DEPTH
   function automatic logic [IDX_W-1:0] wrap_slot(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] ofs);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(ofs);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   logic [IDX_W-1:0]        front_ff, front_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        ofs_ff, ofs_in;
   logic [CNT_W-1:0]        left_ff, left_in;
   logic                    rev_ff, rev_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              status_ff, status_in;
   logic                    last_ff, last_in;
   logic signed [KEY_W-1:0] rd_data_ff;
   logic signed [KEY_W-1:0] store_mem [DEPTH];

   logic [IDX_W-1:0] front_dec;
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] rd_addr;
   logic [CNT_W-1:0] rd_ofs;
   logic             rd_dir;
   logic             rd_en;
   logic             load;

   // write address for pushes
   always_comb begin
      front_dec = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - 1'b1;
      wr_addr   = cmd.at_front ? front_dec : wrap_slot(front_ff, count_ff);
   end

   // dump cursor: first read comes from the start command, later ones from the cursor
   always_comb begin
      rd_en   = cmd.dump_start | cmd.dump_step;
      rd_dir  = cmd.dump_start ? cmd.reverse : rev_ff;
      rd_ofs  = cmd.dump_start ? (cmd.reverse ? count_ff - 1'b1 : '0) : ofs_ff;
      rd_addr = wrap_slot(front_ff, rd_ofs);
      ofs_in  = rd_en ? (rd_dir ? rd_ofs - 1'b1 : rd_ofs + 1'b1) : ofs_ff;
      rev_in  = rd_dir;
      if (cmd.dump_start) begin
         left_in = count_ff - 1'b1;
      end else if (cmd.dump_step) begin
         left_in = left_ff - 1'b1;
      end else begin
         left_in = left_ff;
      end
   end

   // queue pointers
   always_comb begin
      front_in = (cmd.do_push && cmd.at_front) ? front_dec : front_ff;
      count_in = cmd.do_push ? count_ff + 1'b1 : count_ff;
   end

   // output register next values
   always_comb begin
      load      = cmd.do_push | cmd.do_full | cmd.do_empty | rd_en;
      status_in = status_ff;
      last_in   = last_ff;
      if (cmd.do_push) begin
         status_in = ST_ACCEPT;
         last_in   = 1'b1;
      end else if (cmd.do_full) begin
         status_in = ST_FULL;
         last_in   = 1'b1;
      end else if (cmd.do_empty) begin
         status_in = ST_EMPTY;
         last_in   = 1'b1;
      end else if (rd_en) begin
         status_in = ST_ELEM;
         last_in   = cmd.dump_start ? (count_ff == CNT_W'(1)) : (left_ff == CNT_W'(1));
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ofs_ff    <= ofs_in;
      left_ff   <= left_in;
      rev_ff    <= rev_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   // ring store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.do_push) begin
         store_mem[wr_addr] <= key_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // status to controller and response ports
   always_comb begin
      stat.full       = (count_ff == CNT_W'(DEPTH));
      stat.empty      = (count_ff == '0);
      stat.single     = (count_ff == CNT_W'(1));
      stat.final_elem = (left_ff == CNT_W'(1));
      stat.rsp_free   = ~rsp_valid_ff | rsp_ready;
      rsp_valid       = rsp_valid_ff;
      rsp_status      = status_ff;
      rsp_last        = last_ff;
      rsp_key_out     = (status_ff == ST_ELEM) ? rd_data_ff : '0;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("element count above depth");

   a_cmd_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.do_push, cmd.do_full, cmd.do_empty, cmd.dump_start, cmd.dump_step}))
      else $error("more than one datapath command at once");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      cmd.do_push |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not bump the count");
`endif

endmodule

`default_nettype wire

// ===== rtl/deq_eng_ctrl.sv =====
// Controller: decodes requests and sequences dumps one element per transfer.
// Depends on deq_eng_pkg; commands deq_eng_dp.
`default_nettype none

module deq_eng_ctrl import deq_eng_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic [1:0]   req_op,
   input  wire deq_stat_type stat,
   output logic              req_ready,
   output deq_cmd_type       cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_DUMP = 2'b10
   } state_type;

   state_type state_ff, state_in;
   op_type    op;

   // next state and command decode
   always_comb begin
      op        = op_type'(req_op);
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = stat.rsp_free;
            if (req_valid && stat.rsp_free) begin
               case (op)
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     cmd.at_front = (op == OP_PUSH_FRONT);
                     if (stat.full) begin
                        cmd.do_full = 1'b1;
                     end else begin
                        cmd.do_push = 1'b1;
                     end
                  end
                  OP_DUMP_FWD, OP_DUMP_REV: begin
                     cmd.reverse = (op == OP_DUMP_REV);
                     if (stat.empty) begin
                        cmd.do_empty = 1'b1;
                     end else begin
                        cmd.dump_start = 1'b1;
                        if (!stat.single) begin
                           state_in = S_DUMP;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DUMP: begin
            if (stat.rsp_free) begin
               cmd.dump_step = 1'b1;
               if (stat.final_elem) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_dump_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP) |-> !req_ready)
      else $error("request taken during a dump");

   a_cmd_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.do_push || cmd.do_full || cmd.do_empty || cmd.dump_start || cmd.dump_step)
         |-> stat.rsp_free)
      else $error("result issued while the output register is held");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");
`endif

endmodule

`default_nettype wire

// ===== rtl/double_ended_queue_engine_top.sv =====
// Top level of the double-ended queue engine: controller plus datapath.
// Depends on deq_eng_pkg, deq_eng_ctrl and deq_eng_dp.
//
//  Channel   Direction  Handshake             Payload
//  req_      in         req_valid/req_ready   req_op, req_key_in
//  rsp_      out        rsp_valid/rsp_ready   rsp_key_out, rsp_status, rsp_last
//
// A push can be accepted every cycle while rsp_ready is high.
// A dump of N keys emits one element per cycle while rsp_ready is high, limited by the single
// registered read port of the ring store; no request is taken until its last read.
// An empty dump answers with a single ST_EMPTY response.
// Synchronous reset empties the queue at once; the store itself is not cleared.
// A low rsp_ready holds the output register and pauses pushes and dumps alike.
`default_nettype none

module double_ended_queue_engine_top import deq_eng_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [1:0]              req_op,
   input  wire logic signed [KEY_W-1:0] req_key_in,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [KEY_W-1:0]      rsp_key_out,
   output logic [1:0]                   rsp_status,
   output logic                         rsp_last
);

   deq_cmd_type  cmd;
   deq_stat_type stat;

   // request decode and dump sequencing
   deq_eng_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .stat      (stat),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   // store, pointers and output register
   deq_eng_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .key_in      (req_key_in),
      .rsp_ready   (rsp_ready),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_key_out (rsp_key_out),
      .rsp_status  (rsp_status),
      .rsp_last    (rsp_last)
   );

endmodule

`default_nettype wire

// ===== sim/double_ended_queue_engine_top_tb.sv =====
// Self-checking testbench for double_ended_queue_engine_top: a directed stimulus table,
// then random traffic. Responses are checked in order by a deque model or typed row.
// Depends on deq_eng_pkg and the RTL top level double_ended_queue_engine_top.
module double_ended_queue_engine_top_tb;
   import deq_eng_pkg::*;

   localparam int DEPTH        = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 284;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE_LEN   = 16;
   localparam int NUM_ROWS     = 21;

   // one response transfer as the deque model predicts it
   typedef struct {
      logic signed [KEY_W-1:0] key;
      status_type              status;
      logic                    last;
   } deq_rsp_t;

   // one row of the directed table; reps > 1 pushes key, key+1, ...
   typedef struct {
      op_type                  op;
      logic signed [KEY_W-1:0] key;
      int unsigned             reps;
      bit                      typed;
      status_type              want_status;
      logic signed [KEY_W-1:0] want_key;
   } stim_row_t;

   // clock, reset and DUT ports
   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic                    req_ready;
   logic [1:0]              req_op      = OP_PUSH_FRONT;
   logic signed [KEY_W-1:0] req_key_in  = '0;
   logic                    rsp_valid;
   logic                    rsp_ready   = 1'b0;
   logic signed [KEY_W-1:0] rsp_key_out;
   logic [1:0]              rsp_status;
   logic                    rsp_last;

   // deque model state
   logic signed [KEY_W-1:0] ring_keys [DEPTH];
   int unsigned             head_slot  = 0;
   int unsigned             held_count = 0;

   // responses still owed by the DUT, oldest first
   deq_rsp_t awaited[$];

   // traffic shaping
   int unsigned send_idle_pct = 8;
   int unsigned rcv_idle_pct  = 45;
   logic        hold_request  = 1'b0;
   logic        hold_taken    = 1'b0;
   int unsigned hold_left     = 0;

   // bookkeeping
   int unsigned cycle_count  = 0;
   int unsigned mismatches   = 0;
   int unsigned rsp_checked  = 0;
   int unsigned full_seen    = 0;
   int unsigned elem_seen    = 0;
   int unsigned empty_seen   = 0;
   int unsigned directed_cnt = 0;
   int unsigned random_cnt   = 0;

   // directed table: empty dumps, key extremes, ring wrap at the front, fill to full
   stim_row_t script [NUM_ROWS] = '{
      '{OP_DUMP_FWD,   32'sd0,            1,  1'b1, ST_EMPTY,  32'sd0},
      '{OP_DUMP_REV,   32'sd0,            1,  1'b1, ST_EMPTY,  32'sd0},
      '{OP_PUSH_BACK,  32'sh7FFF_FFFF,    1,  1'b1, ST_ACCEPT, 32'sd0},
      '{OP_PUSH_FRONT, 32'sh8000_0000,    1,  1'b1, ST_ACCEPT, 32'sd0},
      '{OP_DUMP_FWD,   32'sd0,            1,  1'b0, ST_ELEM,   32'sd0},
      '{OP_DUMP_REV,   32'sd0,            1,  1'b0, ST_ELEM,   32'sd0},
      '{OP_PUSH_FRONT, 32'shFFFF_FFFF,    1,  1'b1, ST_ACCEPT, 32'sd0},
      '{OP_PUSH_BACK,  32'sd0,            1,  1'b1, ST_ACCEPT, 32'sd0},
      '{OP_PUSH_BACK,  32'sh5555_5555,    1,  1'b0, ST_ACCEPT, 32'sd0},
      '{OP_PUSH_FRONT, 32'shAAAA_AAAA,    1,  1'b0, ST_ACCEPT, 32'sd0},
      '{OP_DUMP_FWD,   32'shFFFF_FFFF,    1,  1'b0, ST_ELEM,   32'sd0},
      '{OP_DUMP_REV,   32'sh7FFF_FFFF,    1,  1'b0, ST_ELEM,   32'sd0},
      '{OP_PUSH_BACK,  32'sd1000,         20, 1'b0, ST_ACCEPT, 32'sd0},
      '{OP_DUMP_FWD,   32'sd0,            1,  1'b0, ST_ELEM,   32'sd0},
      '{OP_PUSH_FRONT, -32'sd500,         37, 1'b0, ST_ACCEPT, 32'sd0},
      '{OP_DUMP_REV,   32'sd0,            1,  1'b0, ST_ELEM,   32'sd0},
      '{OP_PUSH_BACK,  32'sh1234_5678,    1,  1'b1, ST_ACCEPT, 32'sd0},
      '{OP_PUSH_FRONT, 32'sh7FFF_FFFF,    1,  1'b1, ST_FULL,   32'sd0},
      '{OP_PUSH_BACK,  32'sh8000_0000,    1,  1'b1, ST_FULL,   32'sd0},
      '{OP_DUMP_FWD,   32'sd0,            1,  1'b0, ST_ELEM,   32'sd0},
      '{OP_DUMP_REV,   32'sd0,            1,  1'b0, ST_ELEM,   32'sd0}
   };

   double_ended_queue_engine_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_op      (req_op),
      .req_key_in  (req_key_in),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_key_out (rsp_key_out),
      .rsp_status  (rsp_status),
      .rsp_last    (rsp_last)
   );

   always #6 clock = ~clock;

   // apply one request to the deque model; outs receives the responses it causes
   function automatic void deque_apply(input op_type op, input logic signed [KEY_W-1:0] key,
                                       ref deq_rsp_t outs[$]);
      int unsigned n;
      int unsigned i;
      int unsigned slot;
      outs.delete();
      n = held_count;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (n >= DEPTH) begin
               // full store: nothing changes
               outs.push_back('{32'sd0, ST_FULL, 1'b1});
            end else begin
               if (op == OP_PUSH_FRONT) begin
                  head_slot = (head_slot + DEPTH - 1) % DEPTH;
                  ring_keys[head_slot] = key;
               end else begin
                  ring_keys[(head_slot + n) % DEPTH] = key;
               end
               held_count = held_count + 1;
               outs.push_back('{32'sd0, ST_ACCEPT, 1'b1});
            end
         end
         default: begin
            if (n == 0) begin
               outs.push_back('{32'sd0, ST_EMPTY, 1'b1});
            end else begin
               for (i = 0; i < n; i++) begin
                  slot = (op == OP_DUMP_FWD) ? (head_slot + i) % DEPTH
                                             : (head_slot + n - 1 - i) % DEPTH;
                  outs.push_back('{ring_keys[slot], ST_ELEM, (i == n - 1)});
               end
            end
         end
      endcase
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      $display("mismatch @%0d: %s", cycle_count, msg);
   endtask

   // offer one request and wait for its transfer; typed rows carry their own expectation
   task automatic offer(input op_type op, input logic signed [KEY_W-1:0] key,
                        input bit typed, input status_type want_status,
                        input logic signed [KEY_W-1:0] want_key);
      deq_rsp_t fresh[$];
      if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_op     <= op;
      req_key_in <= key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      deque_apply(op, key, fresh);
      if (typed)
         awaited.push_back('{want_key, want_status, 1'b1});
      else
         foreach (fresh[k]) awaited.push_back(fresh[k]);
   endtask

   // stop offering until every owed response has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited.size() != 0) @(posedge clock);
   endtask

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99, 0) >= rcv_idle_pct);
      end
   end

   // response checker: each transfer against the oldest expectation
   always @(posedge clock) begin : check_rsp
      deq_rsp_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited.size() == 0) begin
            note_mismatch($sformatf("unexpected response key %0d status %0d last %0b",
                                    rsp_key_out, rsp_status, rsp_last));
         end else begin
            want = awaited.pop_front();
            rsp_checked++;
            if (rsp_key_out !== want.key)
               note_mismatch($sformatf("key %0d, expected %0d", rsp_key_out, want.key));
            if (rsp_status !== want.status)
               note_mismatch($sformatf("status %0d, expected %s", rsp_status,
                                       want.status.name()));
            if (rsp_last !== want.last)
               note_mismatch($sformatf("last %0b, expected %0b", rsp_last, want.last));
            case (want.status)
               ST_FULL:  full_seen++;
               ST_ELEM:  elem_seen++;
               ST_EMPTY: empty_seen++;
               default:  ;
            endcase
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, awaited.size());
         $display("double_ended_queue_engine_top regression: fail");
         $finish;
      end
   end

   // stimulus: reset, directed table, three random phases with different idling
   initial begin : stimulus
      int unsigned pick;
      int unsigned rep;
      op_type      op;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[r]) begin
         for (rep = 0; rep < script[r].reps; rep++) begin
            offer(script[r].op, script[r].key + rep, script[r].typed,
                  script[r].want_status, script[r].want_key);
            directed_cnt++;
         end
      end
      drain();

      // receiver holds off while the sender keeps pushing into the full store
      hold_request <= 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            drain();
            send_idle_pct = 45;
            rcv_idle_pct  = 8;
         end
         if (n == 2 * RANDOM_ITEMS / 3) begin
            drain();
            send_idle_pct = 0;
            rcv_idle_pct  = 0;
         end
         pick = $urandom_range(99, 0);
         if (pick < 55)
            op = (pick[0]) ? OP_PUSH_BACK : OP_PUSH_FRONT;
         else
            op = (pick[0]) ? OP_DUMP_REV : OP_DUMP_FWD;
         offer(op, $urandom(), 1'b0, ST_ACCEPT, 32'sd0);
         random_cnt++;
      end

      drain();
      repeat (SETTLE_LEN) @(posedge clock);
      $display("covered %0d directed and %0d random requests, store held %0d keys at the end",
               directed_cnt, random_cnt, held_count);
      $display("checked %0d responses: %0d dump elements, %0d empty dumps, %0d full rejects",
               rsp_checked, elem_seen, empty_seen, full_seen);
      if (mismatches == 0)
         $display("double_ended_queue_engine_top regression: pass");
      else
         $display("double_ended_queue_engine_top regression: fail");
      $finish;
   end

endmodule
